@@ rtl/core/bffa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg: shared types and constants for the first-fit bitmap allocator
// Transaction payloads, config register set, controller/datapath handshake.
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam int FIELD_W         = 11;
	localparam int REQ_W           = 2;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;
	localparam int MAX_ENTRIES_DEF = 1024;
	// WORD_BITS must be a power of two (8 .. 64)
	localparam int WORD_BITS_DEF   = 8;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

	// register index is paddr[2]
	localparam logic REG_ENTRY_COUNT  = 1'b0;
	localparam logic REG_FIRST_USABLE = 1'b1;

	localparam logic [FIELD_W-1:0] ENTRY_COUNT_RST  = 11'd1024;
	localparam logic [FIELD_W-1:0] FIRST_USABLE_RST = 11'd0;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [FIELD_W-1:0] entry_number;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] granted_number;
		logic               success;
		logic [FIELD_W-1:0] free_count;
	} rsp_t;

	typedef struct packed {
		logic [FIELD_W-1:0] entry_count;
		logic [FIELD_W-1:0] first_usable;
	} cfg_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic scan;
		logic fm_read;
		logic fm_eval;
		logic fin_fail;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic alloc_none;
		logic num_ok;
		logic scan_hit;
		logic scan_end;
	} sts_t;

endpackage

@@ rtl/core/bitmap_first_free_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_core: first-fit bitmap allocator
// Allocate scans bitmap words one per cycle; free and mark do a
// read-modify-write of one word. One result strobe per transaction.
// ----------------------------------------------------------------------------
// Allocate: words are scanned from the first usable word until a hit or the
//   last usable word (at most MAX_ENTRIES/WORD_BITS words, rounded up);
//   the one-word-per-cycle RAM read sets the pace of the scan.
// Free / mark: read the word (S_FMRD), then evaluate and write it (S_FMEV); rejected or unknown requests go to S_FAIL.
// busy drops in the result cycle, so the next transaction may start there.
// After reset the bitmap RAM is cleared, one word a cycle through every
//   bitmap word; busy stays high until done.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_core #(
	parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF,
	parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bffa_pkg::req_t               req,
	output logic                         busy,
	output logic                         done,
	output bffa_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bffa_pkg::ADDR_W-1:0]  paddr,
	input  logic [bffa_pkg::DATA_W-1:0]  pwdata,
	output logic [bffa_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import bffa_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	bffa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	bffa_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

@@ rtl/core/bffa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/bffa_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_regs: APB configuration registers
// entry_count at 0x0, first_usable at 0x4; zero wait states.
// ----------------------------------------------------------------------------
module bffa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bffa_pkg::ADDR_W-1:0]   paddr,
	input  logic [bffa_pkg::DATA_W-1:0]   pwdata,
	output logic [bffa_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bffa_pkg::cfg_t                cfg
);
	import bffa_pkg::*;

	logic [FIELD_W-1:0] entry_count_q;
	logic [FIELD_W-1:0] first_usable_q;
	logic               wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q  <= ENTRY_COUNT_RST;
			first_usable_q <= FIRST_USABLE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ENTRY_COUNT:  entry_count_q  <= pwdata[FIELD_W-1:0];
				REG_FIRST_USABLE: first_usable_q <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENTRY_COUNT:  prdata = DATA_W'(entry_count_q);
			REG_FIRST_USABLE: prdata = DATA_W'(first_usable_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.entry_count  = entry_count_q;
	assign cfg.first_usable = first_usable_q;

endmodule

@@ rtl/core/bffa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl: allocator sequencer
// Clearing pass after reset, then one request at a time: word scan for
// allocate, read-modify-write for free and mark.
// ----------------------------------------------------------------------------
module bffa_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bffa_pkg::REQ_W-1:0]   req_type,
	input  bffa_pkg::sts_t               sts,
	output bffa_pkg::cmd_t               cmd,
	output logic                         busy
);
	import bffa_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FMRD  = 3'd3;
	localparam logic [2:0] S_FMEV  = 3'd4;
	localparam logic [2:0] S_FAIL  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					unique case (req_type)
						REQ_ALLOC:          state_d = sts.alloc_none ? S_FAIL : S_SCAN;
						REQ_FREE, REQ_MARK: state_d = sts.num_ok ? S_FMRD : S_FAIL;
						default:            state_d = S_FAIL;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit || sts.scan_end) begin
					state_d = S_IDLE;
				end
			end
			S_FMRD: begin
				cmd.fm_read = 1'b1;
				state_d     = S_FMEV;
			end
			S_FMEV: begin
				cmd.fm_eval = 1'b1;
				state_d     = S_IDLE;
			end
			S_FAIL: begin
				cmd.fin_fail = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q != S_IDLE))
		else $error("accepted transaction did not raise busy");

	a_scan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !sts.scan_hit && !sts.scan_end) |=> (state_q == S_SCAN))
		else $error("scan left without hit or end");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (state_q != S_CLEAR))
		else $error("clearing pass re-entered");
`endif

endmodule

@@ rtl/core/bffa_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_dp: allocator datapath
// Bitmap RAM, pipelined word scan with first-fit encoder, used-entry
// counter and the result register.
// ----------------------------------------------------------------------------
module bffa_dp #(
	parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF,
	parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bffa_pkg::cfg_t cfg,
	input  bffa_pkg::req_t req,
	input  bffa_pkg::cmd_t cmd,
	output bffa_pkg::sts_t sts,
	output logic           done,
	output bffa_pkg::rsp_t rsp
);
	import bffa_pkg::*;

	localparam int NUM_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int LOG       = $clog2(WORD_BITS);
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IW        = $clog2(MAX_ENTRIES + 1);
	localparam int CW        = (IW > FIELD_W) ? IW : FIELD_W;

	// config-derived limits in CW bits, word indices in AW bits, bit indices in LOG bits
	logic [CW-1:0]  cnt_c, limit_c, lim_m1_c, fu_c, num_c;
	logic [AW-1:0]  first_w, last_w;
	logic [LOG-1:0] lo_bit, hi_bit;

	assign cnt_c    = CW'(cfg.entry_count);
	assign limit_c  = (cnt_c > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cnt_c;
	assign lim_m1_c = limit_c - CW'(1);
	assign fu_c     = CW'(cfg.first_usable);
	assign num_c    = CW'(req.entry_number);
	assign first_w  = AW'(fu_c >> LOG);
	assign last_w   = AW'(lim_m1_c >> LOG);
	assign lo_bit   = fu_c[LOG-1:0];
	assign hi_bit   = lim_m1_c[LOG-1:0];

	logic [AW-1:0]        clr_q;
	logic [REQ_W-1:0]     req_type_q;
	logic [CW-1:0]        num_idx_q;
	logic [AW:0]          issue_w_q;
	logic [AW-1:0]        eval_w_s1;
	logic                 eval_vld_s1;
	logic [IW-1:0]        used_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, rdata;

	// scan stage
	logic                 issue_ok;
	logic [WORD_BITS-1:0] cand;
	logic [LOG-1:0]       hit_bit;
	logic                 hit, scan_hit, scan_end;
	logic [CW-1:0]        grant_idx;

	// free / mark stage
	logic [AW-1:0]        num_w;
	logic [LOG-1:0]       num_bit;
	logic                 num_set, fm_free, fm_mark;

	logic [CW-1:0]        used_c, used_nxt_c, free_c;
	logic                 fin;

	assign issue_ok = cmd.scan && (issue_w_q <= {1'b0, last_w});

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = !rdata[b]
				&& ((eval_w_s1 != first_w) || (LOG'(b) >= lo_bit))
				&& ((eval_w_s1 != last_w) || (LOG'(b) <= hi_bit));
		end
	end

	// lowest candidate wins
	always_comb begin
		hit_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit_bit = LOG'(b);
			end
		end
	end

	assign hit       = |cand;
	assign scan_hit  = cmd.scan && eval_vld_s1 && hit;
	assign scan_end  = cmd.scan && eval_vld_s1 && !hit && (eval_w_s1 == last_w);
	assign grant_idx = (CW'(eval_w_s1) << LOG) | CW'(hit_bit);

	assign num_w   = AW'(num_idx_q >> LOG);
	assign num_bit = num_idx_q[LOG-1:0];
	assign num_set = rdata[num_bit];
	assign fm_free = cmd.fm_eval && (req_type_q == REQ_FREE) && num_set;
	assign fm_mark = cmd.fm_eval && (req_type_q == REQ_MARK) && !num_set;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = eval_w_s1;
		ram_wdata = rdata | (WORD_BITS'(1) << hit_bit);
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (scan_hit) begin
			ram_we = 1'b1;
		end else if (fm_free) begin
			ram_we    = 1'b1;
			ram_waddr = num_w;
			ram_wdata = rdata & ~(WORD_BITS'(1) << num_bit);
		end else if (fm_mark) begin
			ram_we    = 1'b1;
			ram_waddr = num_w;
			ram_wdata = rdata | (WORD_BITS'(1) << num_bit);
		end
	end

	assign ram_re    = issue_ok || cmd.fm_read;
	assign ram_raddr = cmd.fm_read ? num_w : issue_w_q[AW-1:0];

	bffa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS),
		.AW    (AW)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign used_c = CW'(used_q);

	always_comb begin
		used_nxt_c = used_c;
		if (scan_hit || fm_mark) begin
			used_nxt_c = used_c + CW'(1);
		end else if (fm_free && (used_c != '0)) begin
			used_nxt_c = used_c - CW'(1);
		end
	end

	assign free_c = (limit_c > used_nxt_c) ? (limit_c - used_nxt_c) : '0;
	assign fin    = scan_hit || scan_end || cmd.fm_eval || cmd.fin_fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			issue_w_q   <= '0;
			eval_vld_s1 <= 1'b0;
			used_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= fin;
			used_q      <= IW'(used_nxt_c);
			eval_vld_s1 <= issue_ok && !(scan_hit || scan_end);
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.accept) begin
				issue_w_q <= {1'b0, first_w};
			end else if (issue_ok) begin
				issue_w_q <= issue_w_q + (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q <= req.req_type;
			num_idx_q  <= num_c - CW'(1);
		end
		if (issue_ok) begin
			eval_w_s1 <= issue_w_q[AW-1:0];
		end
		if (fin) begin
			rsp_q.granted_number <= scan_hit ? FIELD_W'(grant_idx + CW'(1)) : '0;
			rsp_q.success        <= scan_hit || fm_free || fm_mark;
			rsp_q.free_count     <= FIELD_W'(free_c);
		end
	end

	assign sts.clr_last   = (clr_q == AW'(NUM_WORDS - 1));
	assign sts.alloc_none = (fu_c >= limit_c);
	assign sts.num_ok     = (num_c != '0) && (num_c <= limit_c);
	assign sts.scan_hit   = scan_hit;
	assign sts.scan_end   = scan_end;

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	a_eval_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		eval_vld_s1 |-> cmd.scan)
		else $error("scan stage valid outside of scan");

	a_grant_success: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((rsp_q.granted_number == '0) || rsp_q.success))
		else $error("entry granted without success");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= IW'(MAX_ENTRIES))
		else $error("used count above capacity");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !(cmd.scan || cmd.fm_eval || fin))
		else $error("bitmap write during clearing pass");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bitmap_first_free_allocator_core
// Drives allocate/free/mark transactions in random bursts over several
// entry-count / first-usable settings written through APB. A shadow bitmap
// predicts every response; responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;
	import bffa_pkg::*;

	localparam int LIMIT_ENTRIES = MAX_ENTRIES_DEF;
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	req_t               req = '0;
	logic               busy;
	logic               done;
	rsp_t               rsp;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// shadow of the allocator state and its registers
	bit [LIMIT_ENTRIES-1:0] shadow_map;
	int                     shadow_used;
	int                     shadow_count;
	int                     shadow_first;

	req_t pending_req[$];
	rsp_t owed_rsp[$];
	int   mismatch_count;
	int   burst_left;
	int   gap_left;

	bitmap_first_free_allocator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int active_entries();
		return (shadow_count > LIMIT_ENTRIES) ? LIMIT_ENTRIES : shadow_count;
	endfunction

	// first-fit allocate / free / mark against the shadow map
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int   lim;
		int   idx;
		lim = active_entries();
		o = '0;
		case (r.req_type)
			REQ_ALLOC: begin
				for (idx = shadow_first; idx < lim && !o.success; idx++) begin
					if (!shadow_map[idx]) begin
						shadow_map[idx] = 1'b1;
						shadow_used++;
						o.granted_number = FIELD_W'(idx + 1);
						o.success = 1'b1;
					end
				end
			end
			REQ_FREE, REQ_MARK: begin
				if (r.entry_number >= 1 && r.entry_number <= lim) begin
					idx = r.entry_number - 1;
					if (r.req_type == REQ_FREE && shadow_map[idx]) begin
						shadow_map[idx] = 1'b0;
						if (shadow_used > 0)
							shadow_used--;
						o.success = 1'b1;
					end else if (r.req_type == REQ_MARK && !shadow_map[idx]) begin
						shadow_map[idx] = 1'b1;
						shadow_used++;
						o.success = 1'b1;
					end
				end
			end
			default: ;
		endcase
		o.free_count = FIELD_W'((lim > shadow_used) ? lim - shadow_used : 0);
		return o;
	endfunction

	function automatic void queue_item(logic [REQ_W-1:0] t, logic [FIELD_W-1:0] num);
		req_t r;
		r.req_type = t;
		r.entry_number = num;
		pending_req.push_back(r);
	endfunction

	// free/mark targets cluster around the allocation front so they hit used bits
	function automatic logic [FIELD_W-1:0] pick_entry();
		int act;
		int hi;
		int lo;
		int r;
		act = active_entries();
		r = $urandom_range(0, 9);
		if (r == 0 || act == 0)
			return FIELD_W'($urandom_range(0, 2047));
		if (r == 1)
			return FIELD_W'(act + $urandom_range(0, 1));
		hi = (shadow_first + 40 < act) ? shadow_first + 40 : act;
		lo = (hi > 48) ? hi - 48 : 1;
		if (r < 8)
			return FIELD_W'($urandom_range(lo, hi));
		return FIELD_W'($urandom_range(1, act));
	endfunction

	task automatic queue_random(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				queue_item(REQ_ALLOC, FIELD_W'($urandom_range(0, 2047)));
			else if (r < 70)
				queue_item(REQ_FREE, pick_entry());
			else if (r < 93)
				queue_item(REQ_MARK, pick_entry());
			else
				queue_item(REQ_UNKNOWN, FIELD_W'($urandom_range(0, 2047)));
		end
	endtask

	task automatic wait_idle();
		while (pending_req.size() != 0 || start || owed_rsp.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic regsel, int val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regsel, 2'b00};
		// upper bits are junk; only the low field bits are kept
		pwdata  <= {DATA_W'($urandom) & ~DATA_W'(2047)} | DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (regsel == REG_ENTRY_COUNT)
			shadow_count = val;
		else
			shadow_first = val;
	endtask

	task automatic run_phase(int cnt, int first, int n);
		wait_idle();
		cfg_write(REG_ENTRY_COUNT, cnt);
		cfg_write(REG_FIRST_USABLE, first);
		queue_random(n);
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
			burst_left = 1;
			gap_left = 0;
		end else if (!(start && busy)) begin
			if (start) begin
				owed_rsp.push_back(apply_request(req));
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_req.size() != 0) begin
				req   <= pending_req.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && done) begin
			if (owed_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected response granted=%0d success=%0d free=%0d",
						$realtime, rsp.granted_number, rsp.success, rsp.free_count);
			end else begin
				want = owed_rsp.pop_front();
				if (rsp.granted_number !== want.granted_number || rsp.success !== want.success ||
				    rsp.free_count !== want.free_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch granted %0d/%0d success %0d/%0d free %0d/%0d (exp/act)",
							$realtime, want.granted_number, rsp.granted_number,
							want.success, rsp.success, want.free_count, rsp.free_count);
				end
			end
		end
	end

	initial begin
		shadow_map = '0;
		shadow_used = 0;
		shadow_count = ENTRY_COUNT_RST;
		shadow_first = FIRST_USABLE_RST;
		mismatch_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, every request type and the edge numbers
		queue_item(REQ_ALLOC, 11'd0);
		queue_item(REQ_ALLOC, 11'd2047);
		queue_item(REQ_ALLOC, 11'd5);
		queue_item(REQ_FREE, 11'd2);
		queue_item(REQ_FREE, 11'd2);       // already free
		queue_item(REQ_ALLOC, 11'd0);      // refills the hole
		queue_item(REQ_MARK, 11'd10);
		queue_item(REQ_MARK, 11'd10);      // already used
		queue_item(REQ_FREE, 11'd1024);
		queue_item(REQ_MARK, 11'd1024);
		queue_item(REQ_ALLOC, 11'd0);
		queue_item(REQ_FREE, 11'd1024);
		queue_item(REQ_FREE, 11'd0);
		queue_item(REQ_MARK, 11'd0);
		queue_item(REQ_MARK, 11'd1025);
		queue_item(REQ_FREE, 11'd2047);
		queue_item(REQ_UNKNOWN, 11'd2047);
		queue_item(REQ_UNKNOWN, 11'd1);
		queue_item(REQ_FREE, 11'd1);
		queue_item(REQ_ALLOC, 11'd1024);

		run_phase(16, 0, 90);       // small map, fills up
		run_phase(16, 11, 60);      // allocation starts past the low entries
		run_phase(4, 0, 50);        // count below used entries
		run_phase(1, 0, 30);
		run_phase(0, 0, 30);        // nothing usable
		run_phase(40, 1024, 30);    // first usable past the count
		run_phase(2047, 1000, 80);  // oversize count clamps to the maximum
		run_phase(1024, 1023, 30);
		run_phase(1024, 0, 90);
		run_phase(200, 190, 80);
		run_phase(64, 63, 60);
		run_phase(1024, 2047, 20);

		wait_idle();
		repeat (140) @(posedge clk);
		if (mismatch_count == 0 && owed_rsp.size() == 0) begin
			$display("PASS bitmap_first_free_allocator_core");
		end else begin
			if (owed_rsp.size() != 0)
				$display("%0d responses never arrived", owed_rsp.size());
			$display("FAIL bitmap_first_free_allocator_core");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("FAIL bitmap_first_free_allocator_core");
		$finish;
	end

endmodule

@@ bitmap_first_free_allocator_core.f @@
rtl/core/bffa_pkg.sv
rtl/core/bffa_ram.sv
rtl/core/bffa_regs.sv
rtl/core/bffa_ctrl.sv
rtl/core/bffa_dp.sv
rtl/core/bitmap_first_free_allocator_core.sv
dv/tb.sv
